FILE: design/bsact_pkg.sv
// ----------------------------------------------------------------------------
// bsact_pkg
// Shared types, codes and helpers for the banked set-associative tag store.
// ----------------------------------------------------------------------------
package bsact_pkg;

    localparam int ADDR_W = 48;
    localparam int LFSR_W = 16;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_INVAL = 2'd2;

    localparam logic [1:0] EFF_NONE  = 2'd0;
    localparam logic [1:0] EFF_CLEAN = 2'd1;
    localparam logic [1:0] EFF_DIRTY = 2'd2;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] addr;
    } in_t;

    typedef struct packed {
        logic              hit;
        logic [1:0]        effect;
        logic              evicted_valid;
        logic              evicted_dirty;
        logic [ADDR_W-1:0] evicted_addr;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic finish;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } sts_t;

    function automatic int flog2(input int x);
        int n;
        int v;
        n = 0;
        v = x;
        while (v > 1)
        begin
            v = v >> 1;
            n++;
        end
        return n;
    endfunction

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] r;
        r = s >> 1;
        if (s[0])
        begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

FILE: design/bsact_ram.sv
// ----------------------------------------------------------------------------
// bsact_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/bsact_ctrl.sv
// ----------------------------------------------------------------------------
// bsact_ctrl
// Sequencer: post-reset clear sweep, accept, lookup/update, result handoff.
// ----------------------------------------------------------------------------
module bsact_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bsact_pkg::sts_t    sts,
    output bsact_pkg::ctl_t    ctl
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign ctl.clear  = (state_reg == S_CLEAR);
    assign ctl.load   = in_ready && in_valid;
    assign ctl.finish = (state_reg == S_LOOK) && !sts.out_busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_load_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> state_reg == S_LOOK)
        else $error("accepted transaction did not enter lookup");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && sts.out_busy) |=> state_reg == S_LOOK)
        else $error("lookup left while result register busy");
    a_clear_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && !sts.clear_last) |=> state_reg == S_CLEAR && !in_ready)
        else $error("clear sweep ended early");
`endif

endmodule

FILE: design/bsact_dp.sv
// ----------------------------------------------------------------------------
// bsact_dp
// Tag RAM, way compare, victim selection, line update and result register.
// ----------------------------------------------------------------------------
module bsact_dp #(
    parameter int LINE_BYTES = 64,
    parameter int SETS       = 64,
    parameter int WAYS       = 8,
    parameter int BANKS      = 4,
    parameter int ADDR_BITS  = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bsact_pkg::ctl_t                   ctl,
    output bsact_pkg::sts_t                   sts,
    input  bsact_pkg::in_t                    in_data,
    input  logic                              cfg_valid,
    input  logic [bsact_pkg::LFSR_W-1:0]      cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bsact_pkg::out_t                   out_data
);

    localparam int AW        = bsact_pkg::ADDR_W;
    localparam int OFF_BITS  = bsact_pkg::flog2(LINE_BYTES);
    localparam int SET_BITS  = bsact_pkg::flog2(SETS);
    localparam int BANK_BITS = bsact_pkg::flog2(BANKS);
    localparam int TAG_START = OFF_BITS + SET_BITS + BANK_BITS;
    localparam int EA        = (ADDR_BITS < AW) ? ADDR_BITS : AW;
    localparam int TAG_BITS  = (EA > TAG_START) ? (EA - TAG_START) : 0;
    localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
    localparam int ROWS      = BANKS * SETS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_W    = TAG_W + 3;
    localparam int WORD_W    = WAYS * LINE_W;
    localparam int B_DIRTY   = TAG_W;
    localparam int B_VALID   = TAG_W + 1;
    localparam int B_INST    = TAG_W + 2;

    localparam logic [AW-1:0] EA_MASK   = AW'((65'd1 << EA) - 65'd1);
    localparam logic [AW-1:0] SET_MASK  = AW'((65'd1 << SET_BITS) - 65'd1);
    localparam logic [AW-1:0] BANK_MASK = AW'((65'd1 << BANK_BITS) - 65'd1);
    localparam logic [AW-1:0] MID_MASK  =
        AW'(((65'd1 << TAG_START) - 65'd1) ^ ((65'd1 << OFF_BITS) - 65'd1));
    localparam logic [32:0] RECIP =
        33'(((64'd1 << 32) + 64'(WAYS) - 64'd1) / 64'(WAYS));

    logic [ROW_W-1:0]                   clr_cnt_reg;
    logic [bsact_pkg::LFSR_W-1:0]       lfsr_reg;
    logic [1:0]                         cmd_reg;
    logic [AW-1:0]                      addr_reg;
    logic [ROW_W-1:0]                   row_reg;
    logic [16:0]                        q_reg;
    logic                               out_valid_reg;
    bsact_pkg::out_t                    out_data_reg;
    bsact_pkg::out_t                    out_data_next;

    logic [AW-1:0]                      in_addr_m;
    logic [ROW_W-1:0]                   in_set;
    logic [ROW_W-1:0]                   in_bank;
    logic [ROW_W-1:0]                   in_row;
    logic [bsact_pkg::LFSR_W-1:0]       lfsr_nx;
    logic [48:0]                        prod;
    logic [16:0]                        qw;
    logic [bsact_pkg::LFSR_W-1:0]       rem;
    logic [WAY_W-1:0]                   victim;

    logic [WAYS-1:0][LINE_W-1:0]        rd_word;
    logic [WAYS-1:0][LINE_W-1:0]        wr_word;
    logic [WORD_W-1:0]                  rd_flat;
    logic [WAYS-1:0]                    match;
    logic [TAG_W-1:0]                   tag_cur;
    logic [LINE_W-1:0]                  vline;
    logic                               found;
    logic                               is_mem;
    logic                               is_inv;
    logic                               miss;
    logic                               upd;
    logic                               ram_we;
    logic [ROW_W-1:0]                   ram_waddr;
    logic [WORD_W-1:0]                  ram_wdata;

    // address split of the incoming transaction
    assign in_addr_m = in_data.addr & EA_MASK;
    assign in_set    = ROW_W'((in_addr_m >> OFF_BITS) & SET_MASK);
    assign in_bank   = ROW_W'((in_addr_m >> (OFF_BITS + SET_BITS)) & BANK_MASK);
    assign in_row    = ROW_W'(in_bank * ROW_W'(SETS) + in_set);

    // victim way = next LFSR value mod WAYS via reciprocal
    assign lfsr_nx = bsact_pkg::lfsr_next(lfsr_reg);
    assign prod    = 49'(lfsr_nx) * 49'(RECIP);
    assign qw      = 17'(q_reg * 17'(WAYS));
    assign rem     = lfsr_nx - qw[bsact_pkg::LFSR_W-1:0];
    assign victim  = rem[WAY_W-1:0];

    bsact_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ctl.load),
        .rd_addr (in_row),
        .rd_data (rd_flat)
    );

    assign rd_word = rd_flat;
    assign tag_cur = TAG_W'(addr_reg >> TAG_START);
    assign is_mem  = (cmd_reg == bsact_pkg::CMD_LOAD) || (cmd_reg == bsact_pkg::CMD_STORE);
    assign is_inv  = (cmd_reg == bsact_pkg::CMD_INVAL);

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = rd_word[w][B_VALID] && (rd_word[w][TAG_W-1:0] == tag_cur);
        end
    end

    assign found = |match;
    assign miss  = is_mem && !found;
    assign upd   = miss || (is_inv && found);
    assign vline = rd_word[victim];

    always_comb
    begin
        wr_word = rd_word;
        for (int w = 0; w < WAYS; w++)
        begin
            if (is_inv && match[w])
            begin
                wr_word[w][B_VALID] = 1'b0;
            end
            if (miss && (WAY_W'(w) == victim))
            begin
                wr_word[w] = {1'b1, 1'b1, (cmd_reg == bsact_pkg::CMD_STORE), tag_cur};
            end
        end
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next.hit = (is_mem || is_inv) && found;
        if (miss)
        begin
            out_data_next.effect        = vline[B_DIRTY] ? bsact_pkg::EFF_DIRTY
                                                         : bsact_pkg::EFF_CLEAN;
            out_data_next.evicted_valid = vline[B_VALID];
            out_data_next.evicted_dirty = vline[B_DIRTY];
            if (vline[B_INST])
            begin
                out_data_next.evicted_addr =
                    (AW'(vline[TAG_W-1:0]) << TAG_START) | (addr_reg & MID_MASK);
            end
        end
    end

    assign ram_we    = ctl.clear || (ctl.finish && upd);
    assign ram_waddr = ctl.clear ? clr_cnt_reg : row_reg;
    assign ram_wdata = ctl.clear ? '0 : WORD_W'(wr_word);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            lfsr_reg      <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
            end
            if (cfg_valid)
            begin
                lfsr_reg <= cfg_data;
            end
            else if (ctl.finish && miss)
            begin
                lfsr_reg <= lfsr_nx;
            end
            if (ctl.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= in_data.cmd;
            addr_reg <= in_addr_m;
            row_reg  <= in_row;
            q_reg    <= prod[48:32];
        end
        if (ctl.finish)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == ROW_W'(ROWS - 1));
    assign sts.out_busy   = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;

`ifndef SYNTHESIS
    a_finish_fills: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> out_valid_reg)
        else $error("finished transaction not presented");
    a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.effect != bsact_pkg::EFF_NONE) |-> !out_data_reg.hit)
        else $error("eviction reported on a hit");
    a_no_evict_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.effect == bsact_pkg::EFF_NONE) |->
            (out_data_reg.evicted_addr == '0 && !out_data_reg.evicted_valid
             && !out_data_reg.evicted_dirty))
        else $error("victim fields set without eviction");
    a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> !ctl.load && !ctl.finish)
        else $error("transaction overlaps clear sweep");
`endif

endmodule

FILE: design/banked_set_assoc_cache_tags.sv
// ----------------------------------------------------------------------------
// banked_set_assoc_cache_tags
// Banked set-associative cache tag store with LFSR random replacement.
//
//   channel | signals                      | direction
//   --------+------------------------------+----------
//   in      | in_valid in_ready in_data    | request
//   out     | out_valid out_ready out_data | result
//   cfg     | cfg_valid cfg_ready cfg_data | LFSR seed write
//
// One transaction at a time: a registered read of the whole set row, then
// compare and write-back in the lookup state over the single RAM port pair.
// After reset the tag RAM is swept clear, all BANKS*SETS rows (256 by default),
// with in_ready low; cfg writes are taken at any time.
// A full result register stalls the lookup cycle until out_ready.
// ----------------------------------------------------------------------------
module banked_set_assoc_cache_tags #(
    parameter int LINE_BYTES = 64,
    parameter int SETS       = 64,
    parameter int WAYS       = 8,
    parameter int BANKS      = 4,
    parameter int ADDR_BITS  = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bsact_pkg::in_t                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bsact_pkg::out_t               out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsact_pkg::LFSR_W-1:0]  cfg_data
);

    bsact_pkg::ctl_t ctl;
    bsact_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    bsact_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    bsact_dp #(
        .LINE_BYTES (LINE_BYTES),
        .SETS       (SETS),
        .WAYS       (WAYS),
        .BANKS      (BANKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - banked set-associative cache tag store testbench
// Drives load, store, invalidate and unused-command transactions into the
// tag store and compares every result with a shadow copy of the tag arrays
// and the replacement LFSR. Directed cases come first (hits, misses, edge
// addresses, set overflow, seed extremes), then phases of random traffic
// that reuse a small pool of sets and tags so hits and evictions are common.
// Input bursts with gaps and a shifting output stall pattern vary the timing.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WAYS       = 8;
    localparam int          NLINES     = 2048;
    localparam int          LIMIT      = 400000;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    bsact_pkg::in_t   in_data;
    logic             out_valid;
    logic             out_ready;
    bsact_pkg::out_t  out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [15:0]      cfg_data;

    // shadow of the tag store
    logic        shadow_valid [NLINES];
    logic        shadow_dirty [NLINES];
    logic [33:0] shadow_tag   [NLINES];
    logic [41:0] shadow_line  [NLINES];
    logic [15:0] shadow_lfsr;

    bsact_pkg::out_t  pending_results [$];
    bsact_pkg::out_t  want;

    int          errors;
    int          cycle_count;
    int          n_items;
    int          n_hits;
    int          n_clean_ev;
    int          n_dirty_ev;
    int          n_inval_hits;
    int          n_seeds;

    int          tx_burst_left;
    bit          tx_gappy;
    int          rx_mode;
    int          rx_hold;

    // random traffic pools
    logic [33:0] pool_tag  [12];
    logic [5:0]  pool_set  [2];
    logic [1:0]  pool_bank [2];

    banked_set_assoc_cache_tags i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // expected outcome of one request; updates the shadow store
    function automatic bsact_pkg::out_t tag_lookup(bsact_pkg::in_t req);
        bsact_pkg::out_t res;
        logic [33:0]     tag;
        int              base;
        int              vic;
        int              w;
        logic            found;
        res   = '0;
        found = 1'b0;
        tag   = req.addr[47:14];
        base  = int'({req.addr[13:12], req.addr[11:6]}) * WAYS;
        if (req.cmd == CMD_UNUSED)
        begin
            return res;
        end
        for (w = 0; w < WAYS; w++)
        begin
            if (shadow_valid[base + w] && shadow_tag[base + w] == tag)
            begin
                found = 1'b1;
                if (req.cmd == bsact_pkg::CMD_INVAL)
                begin
                    shadow_valid[base + w] = 1'b0;
                end
            end
        end
        if (req.cmd == bsact_pkg::CMD_INVAL || found)
        begin
            res.hit = found;
            return res;
        end
        shadow_lfsr = (shadow_lfsr >> 1) ^ (shadow_lfsr[0] ? bsact_pkg::LFSR_TAPS : 16'h0000);
        vic = base + int'(shadow_lfsr[2:0]);
        res.effect        = shadow_dirty[vic] ? bsact_pkg::EFF_DIRTY : bsact_pkg::EFF_CLEAN;
        res.evicted_valid = shadow_valid[vic];
        res.evicted_dirty = shadow_dirty[vic];
        res.evicted_addr  = {shadow_line[vic], 6'b000000};
        shadow_tag[vic]   = tag;
        shadow_dirty[vic] = (req.cmd == bsact_pkg::CMD_STORE);
        shadow_valid[vic] = 1'b1;
        shadow_line[vic]  = req.addr[47:6];
        return res;
    endfunction

    // called right after a rising edge; returns at the accepting edge
    task automatic send_request(logic [1:0] cmd, logic [47:0] addr);
        bsact_pkg::in_t  req;
        bsact_pkg::out_t res;
        int              gap;
        req.cmd  = cmd;
        req.addr = addr;
        if (tx_burst_left == 0)
        begin
            tx_burst_left = $urandom_range(24, 1);
            gap = (tx_gappy && $urandom_range(3) != 0) ? $urandom_range(6, 1) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        tx_burst_left--;
        res = tag_lookup(req);
        pending_results.push_back(res);
        n_items++;
        if (req.cmd == bsact_pkg::CMD_INVAL && res.hit)
        begin
            n_inval_hits++;
        end
        else if (res.hit)
        begin
            n_hits++;
        end
        else if (res.effect == bsact_pkg::EFF_DIRTY)
        begin
            n_dirty_ev++;
        end
        else if (res.effect == bsact_pkg::EFF_CLEAN)
        begin
            n_clean_ev++;
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_seed(logic [15:0] seed);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        shadow_lfsr = seed;
        n_seeds++;
        cfg_valid <= 1'b0;
    endtask

    task automatic report(string name, logic [47:0] exp_v, logic [47:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no transaction pending, actual %h",
                         $realtime, out_data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                report("hit", 48'(want.hit), 48'(out_data.hit));
                report("effect", 48'(want.effect), 48'(out_data.effect));
                report("evicted_valid", 48'(want.evicted_valid), 48'(out_data.evicted_valid));
                report("evicted_dirty", 48'(want.evicted_dirty), 48'(out_data.evicted_dirty));
                report("evicted_addr", want.evicted_addr, out_data.evicted_addr);
            end
        end
    end

    // receiver stall pattern: mode is redrawn whenever its hold counter runs out
    always @(posedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_mode <= $urandom_range(3);
            rx_hold <= $urandom_range(300, 64);
        end
        else
        begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= cycle_count[0];
            2: out_ready <= ($urandom_range(9) >= 3);
            default: out_ready <= ((cycle_count % 16) >= 10);
        endcase
    end

    function automatic logic [47:0] pool_addr();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        if ($urandom_range(4) == 0)
        begin
            return wide[47:0];
        end
        return {pool_tag[$urandom_range(11)], pool_bank[$urandom_range(1)],
                pool_set[$urandom_range(1)], wide[5:0]};
    endfunction

    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 40)
        begin
            return bsact_pkg::CMD_LOAD;
        end
        if (r < 75)
        begin
            return bsact_pkg::CMD_STORE;
        end
        if (r < 93)
        begin
            return bsact_pkg::CMD_INVAL;
        end
        return CMD_UNUSED;
    endfunction

    task automatic new_pools;
        int i;
        logic [63:0] wide;
        for (i = 0; i < 12; i++)
        begin
            wide = {$urandom, $urandom};
            pool_tag[i] = wide[33:0];
        end
        pool_tag[0] = '0;
        pool_tag[1] = '1;
        for (i = 0; i < 2; i++)
        begin
            pool_set[i]  = 6'($urandom);
            pool_bank[i] = 2'($urandom);
        end
    endtask

    task automatic test_directed;
        int i;
        send_request(bsact_pkg::CMD_LOAD, 48'h0);
        send_request(bsact_pkg::CMD_LOAD, 48'h3F);
        send_request(bsact_pkg::CMD_STORE, 48'h0);
        send_request(bsact_pkg::CMD_STORE, 48'hFFFF_FFFF_FFFF);
        send_request(bsact_pkg::CMD_LOAD, 48'hFFFF_FFFF_FFC0);
        send_request(bsact_pkg::CMD_INVAL, 48'hFFFF_FFFF_FFFF);
        send_request(bsact_pkg::CMD_INVAL, 48'hFFFF_FFFF_FFFF);
        send_request(CMD_UNUSED, 48'hFFFF_FFFF_FFFF);
        send_request(CMD_UNUSED, 48'h0);
        // overflow bank 0 set 0 with dirty lines
        for (i = 1; i <= 10; i++)
        begin
            send_request(bsact_pkg::CMD_STORE, 48'(i) << 14);
        end
        send_request(bsact_pkg::CMD_LOAD, 48'h0);
        send_request(bsact_pkg::CMD_INVAL, 48'h0);
        send_request(bsact_pkg::CMD_LOAD, 48'h0000_0000_3FFF);
        drain();
    endtask

    task automatic test_seed_extremes;
        int i;
        // zero seed: victim is always way 0
        write_seed(16'h0000);
        for (i = 0; i < 10; i++)
        begin
            send_request(bsact_pkg::CMD_STORE, {34'(i + 100), 2'd1, 6'd5, 6'($urandom)});
        end
        write_seed(16'hFFFF);
        for (i = 0; i < 10; i++)
        begin
            send_request(i[0] ? bsact_pkg::CMD_LOAD : bsact_pkg::CMD_STORE,
                         {34'(i + 200), 2'd2, 6'd9, 6'd0});
        end
        write_seed(16'h0001);
    endtask

    task automatic test_random_phases;
        int phase;
        int i;
        for (phase = 0; phase < 6; phase++)
        begin
            write_seed(16'($urandom_range(65535, 1)));
            new_pools();
            tx_gappy = (phase != 0);
            for (i = 0; i < 300; i++)
            begin
                if (phase == 3 && i == 150)
                begin
                    drain();
                end
                send_request(pick_cmd(), pool_addr());
            end
        end
        drain();
    endtask

    initial
    begin
        int i;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        out_ready     = 1'b0;
        rx_mode       = 0;
        rx_hold       = 0;
        errors        = 0;
        cycle_count   = 0;
        n_items       = 0;
        n_hits        = 0;
        n_clean_ev    = 0;
        n_dirty_ev    = 0;
        n_inval_hits  = 0;
        n_seeds       = 0;
        tx_burst_left = 0;
        tx_gappy      = 1'b1;
        for (i = 0; i < NLINES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
            shadow_tag[i]   = '0;
            shadow_line[i]  = '0;
        end
        shadow_lfsr = 16'h0001;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_seed_extremes();
        test_random_phases();

        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $realtime, pending_results.size());
            errors++;
        end
        $display("Ran %0d transactions, %0d seed writes: %0d hits, %0d invalidate hits,",
                 n_items, n_seeds, n_hits, n_inval_hits);
        $display("  %0d clean and %0d dirty evictions, %0d mismatches",
                 n_clean_ev, n_dirty_ev, errors);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
